>>> rtl/hsle_pkg.sv
// ----------------------------------------------------------------------------
// HSL / RGB LED frame encoder package
// Shared payload types, frame layout and fixed-point conversion constants.
// ----------------------------------------------------------------------------
package hsle_pkg;

    // Colour request selectors
    localparam logic [1:0] OP_DIRECT = 2'd0;
    localparam logic [1:0] OP_HSL    = 2'd1;
    localparam logic [1:0] OP_PACKED = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] packed_color;
        logic [15:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  lightness;
    } t_in;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // Colour queue between conversion and serialiser
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Frame layout
    localparam int FRAME_LEN = 10;
    localparam int IDXW      = $clog2(FRAME_LEN);
    localparam logic [IDXW-1:0] IDX_G    = IDXW'(4);
    localparam logic [IDXW-1:0] IDX_R    = IDXW'(5);
    localparam logic [IDXW-1:0] IDX_B    = IDXW'(6);
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(FRAME_LEN - 1);
    localparam logic [7:0]      ZERO_BYTE = 8'h00;
    localparam logic [7:0]      MARK_BYTE = 8'h80;

    // Clamp and angle constants
    localparam logic [6:0] PCT_MAX  = 7'd99;
    localparam logic [6:0] PCT_FULL = 7'd100;
    localparam logic [8:0] DEG_FULL = 9'd360;

    // Ceiling reciprocals: floor(n / d) = (n * RECIP) >> SHIFT over each input range
    localparam logic [13:0] HUE_RECIP = 14'd11651;   // hue / 360, hue < 2^16
    localparam int          HUE_SHIFT = 22;
    localparam logic [17:0] C_RECIP   = 18'd214749;  // (p * 256) / 10000
    localparam int          C_SHIFT   = 23;
    localparam logic [15:0] M_RECIP   = 16'd41944;   // (l * 512) / 100
    localparam int          M_SHIFT   = 13;
    localparam logic [16:0] H2_RECIP  = 17'd69906;   // (r * 256) / 60
    localparam int          H2_SHIFT  = 14;

    function automatic logic [7:0] frame_byte_at(t_rgb col, logic [IDXW-1:0] idx);
        logic [7:0] res;
        res = ZERO_BYTE;
        if (idx == IDX_G) begin
            res = MARK_BYTE | {1'b0, col.g[7:1]};
        end else if (idx == IDX_R) begin
            res = MARK_BYTE | {1'b0, col.r[7:1]};
        end else if (idx == IDX_B) begin
            res = MARK_BYTE | {1'b0, col.b[7:1]};
        end else if (idx > IDX_B) begin
            res = MARK_BYTE;
        end
        return res;
    endfunction

endpackage

>>> rtl/hsle_front.sv
// ----------------------------------------------------------------------------
// HSL / RGB LED frame encoder front end
// Accepts colour requests and converts them to RGB in a six-stage pipeline.
// ----------------------------------------------------------------------------
module hsle_front
    import hsle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_in  i_item,
    output logic o_q_push,
    output t_rgb o_q_data,
    input  logic i_q_full
);

    logic advance;

    // Stage registers
    logic        r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld;
    logic        r_a_hsl, r_b_hsl, r_c_hsl, r_d_hsl, r_e_hsl, r_f_hsl;
    t_rgb        r_a_rgb, r_b_rgb, r_c_rgb, r_d_rgb, r_e_rgb, r_f_rgb;
    logic [15:0] r_a_hue, r_b_hue;
    logic [6:0]  r_a_s, r_a_l;
    logic [7:0]  r_b_q;
    logic [13:0] r_b_p;
    logic [8:0]  r_b_v, r_c_v, r_d_v;
    logic [8:0]  r_c_h;
    logic [7:0]  r_c_c, r_d_c, r_e_c, r_f_c;
    logic [2:0]  r_d_h1, r_e_h1, r_f_h1;
    logic [5:0]  r_d_r;
    logic [7:0]  r_e_h2;
    logic [7:0]  r_e_m, r_f_m;
    logic [7:0]  r_f_x;

    // Next values
    logic [6:0]  n_a_s, n_a_l;
    t_rgb        n_a_rgb;
    logic [7:0]  dbl_l;
    logic [6:0]  span;
    logic [13:0] n_b_p;
    logic [29:0] hue_prod;
    logic [22:0] v_prod;
    logic [16:0] q360;
    logic [15:0] h_full;
    logic [31:0] c_prod;
    logic [2:0]  n_d_h1;
    logic [8:0]  sext_base;
    logic [8:0]  r_full;
    logic [22:0] h2_prod;
    logic signed [9:0] diff, diff_adj, m_full;
    logic [8:0]  weight;
    logic [16:0] x_prod;
    logic [7:0]  rc, gc, bc;

    // Stall the whole pipeline while its last stage cannot drain
    assign advance  = !(r_f_vld && i_q_full);
    assign o_full   = !advance;
    assign o_q_push = r_f_vld && !i_q_full;

    // Stage A inputs
    always_comb begin
        n_a_s   = (i_item.saturation > 8'(PCT_MAX)) ? PCT_MAX : i_item.saturation[6:0];
        n_a_l   = (i_item.lightness  > 8'(PCT_MAX)) ? PCT_MAX : i_item.lightness[6:0];
        n_a_rgb = (i_item.operation == OP_PACKED) ? t_rgb'(i_item.packed_color)
                                                  : {i_item.red, i_item.green, i_item.blue};
    end

    // Stage B: chroma product, hue quotient, lightness offset
    always_comb begin
        dbl_l    = {r_a_l, 1'b0};
        span     = (dbl_l >= 8'(PCT_FULL)) ? 7'(8'd200 - dbl_l) : dbl_l[6:0];
        n_b_p    = span * r_a_s;
        hue_prod = r_a_hue * HUE_RECIP;
        v_prod   = r_a_l * M_RECIP;
    end

    // Stage C: hue mod 360, chroma
    always_comb begin
        q360   = r_b_q * DEG_FULL;
        h_full = r_b_hue - q360[15:0];
        c_prod = r_b_p * C_RECIP;
    end

    // Stage D: sextant and offset within it
    always_comb begin
        priority if (r_c_h < 9'd60) begin
            n_d_h1 = 3'd0; sext_base = 9'd0;
        end else if (r_c_h < 9'd120) begin
            n_d_h1 = 3'd1; sext_base = 9'd60;
        end else if (r_c_h < 9'd180) begin
            n_d_h1 = 3'd2; sext_base = 9'd120;
        end else if (r_c_h < 9'd240) begin
            n_d_h1 = 3'd3; sext_base = 9'd180;
        end else if (r_c_h < 9'd300) begin
            n_d_h1 = 3'd4; sext_base = 9'd240;
        end else begin
            n_d_h1 = 3'd5; sext_base = 9'd300;
        end
        r_full = r_c_h - sext_base;
    end

    // Stage E: scaled offset, lightness match value (division truncates toward zero)
    always_comb begin
        h2_prod  = r_d_r * H2_RECIP;
        diff     = $signed({1'b0, r_d_v}) - $signed({2'b00, r_d_c});
        diff_adj = diff + $signed({9'd0, diff[9]});
        m_full   = diff_adj >>> 1;
    end

    // Stage F: second largest component
    always_comb begin
        weight = r_e_h1[0] ? (9'd256 - {1'b0, r_e_h2}) : {1'b0, r_e_h2};
        x_prod = r_e_c * weight;
    end

    // Output: place components by sextant, add the match value
    always_comb begin
        unique case (r_f_h1)
            3'd0: begin rc = r_f_c; gc = r_f_x; bc = 8'd0;  end
            3'd1: begin rc = r_f_x; gc = r_f_c; bc = 8'd0;  end
            3'd2: begin rc = 8'd0;  gc = r_f_c; bc = r_f_x; end
            3'd3: begin rc = 8'd0;  gc = r_f_x; bc = r_f_c; end
            3'd4: begin rc = r_f_x; gc = 8'd0;  bc = r_f_c; end
            default: begin rc = r_f_c; gc = 8'd0; bc = r_f_x; end
        endcase
        if (r_f_hsl) begin
            o_q_data = {8'(rc + r_f_m), 8'(gc + r_f_m), 8'(bc + r_f_m)};
        end else begin
            o_q_data = r_f_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (advance) begin
            r_a_vld <= i_push;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_hsl <= (i_item.operation == OP_HSL);
            r_a_rgb <= n_a_rgb;
            r_a_hue <= i_item.hue;
            r_a_s   <= n_a_s;
            r_a_l   <= n_a_l;

            r_b_hsl <= r_a_hsl;
            r_b_rgb <= r_a_rgb;
            r_b_hue <= r_a_hue;
            r_b_q   <= hue_prod[HUE_SHIFT +: 8];
            r_b_p   <= n_b_p;
            r_b_v   <= v_prod[M_SHIFT +: 9];

            r_c_hsl <= r_b_hsl;
            r_c_rgb <= r_b_rgb;
            r_c_v   <= r_b_v;
            r_c_h   <= h_full[8:0];
            r_c_c   <= c_prod[C_SHIFT +: 8];

            r_d_hsl <= r_c_hsl;
            r_d_rgb <= r_c_rgb;
            r_d_v   <= r_c_v;
            r_d_c   <= r_c_c;
            r_d_h1  <= n_d_h1;
            r_d_r   <= r_full[5:0];

            r_e_hsl <= r_d_hsl;
            r_e_rgb <= r_d_rgb;
            r_e_c   <= r_d_c;
            r_e_h1  <= r_d_h1;
            r_e_h2  <= h2_prod[H2_SHIFT +: 8];
            r_e_m   <= m_full[7:0];

            r_f_hsl <= r_e_hsl;
            r_f_rgb <= r_e_rgb;
            r_f_c   <= r_e_c;
            r_f_h1  <= r_e_h1;
            r_f_m   <= r_e_m;
            r_f_x   <= x_prod[15:8];
        end
    end

    // A stalled result stays in the last stage
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_vld && i_q_full) |=> r_f_vld)
        else $error("front: stalled colour dropped");

endmodule

>>> rtl/hsle_queue.sv
// ----------------------------------------------------------------------------
// HSL / RGB LED frame encoder colour queue
// Short FIFO of converted colours between front end and serialiser.
// ----------------------------------------------------------------------------
module hsle_queue
    import hsle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rgb i_data,
    output logic o_full,
    input  logic i_pop,
    output t_rgb o_data,
    output logic o_empty
);

    t_rgb           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= QAW'(r_wp + 1'b1);
            end
            if (do_pop) begin
                r_rp <= QAW'(r_rp + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= QCW'(r_cnt + 1'b1);
            end else if (do_pop && !do_push) begin
                r_cnt <= QCW'(r_cnt - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(QDEPTH))
        else $error("queue: fill count beyond depth");

    a_cnt_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QAW'(r_wp - r_rp) == r_cnt[QAW-1:0])
        else $error("queue: pointers disagree with fill count");

endmodule

>>> rtl/hsle_back.sv
// ----------------------------------------------------------------------------
// HSL / RGB LED frame encoder serialiser
// Turns each queued colour into ten frame bytes behind an output register.
// ----------------------------------------------------------------------------
module hsle_back
    import hsle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_rgb i_q_data,
    output logic o_q_pop,
    output logic o_empty,
    input  logic i_pop,
    output t_out o_item
);

    t_rgb            r_col;
    logic            r_col_vld;
    logic [IDXW-1:0] r_idx;
    logic            r_out_vld;
    t_out            r_out;
    logic            load, emit, fin, take;

    assign load    = !r_out_vld || i_pop;
    assign emit    = load && r_col_vld;
    assign fin     = emit && (r_idx == IDX_LAST);
    assign take    = !r_col_vld || fin;
    assign o_q_pop = take && !i_q_empty;
    assign o_empty = !r_out_vld;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_vld <= 1'b0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (take) begin
                r_col_vld <= !i_q_empty;
            end
            if (emit) begin
                r_idx <= fin ? '0 : IDXW'(r_idx + 1'b1);
            end
            if (load) begin
                r_out_vld <= r_col_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_col <= i_q_data;
        end
        if (emit) begin
            r_out.frame_byte <= frame_byte_at(r_col, r_idx);
            r_out.last_byte  <= (r_idx == IDX_LAST);
        end
    end

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.last_byte) |-> (r_out.frame_byte == MARK_BYTE))
        else $error("back: last byte is not a marker byte");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> (r_idx == '0))
        else $error("back: byte index not rewound after frame");

endmodule

>>> rtl/hsl_rgb_led_frame_encoder.sv
// ----------------------------------------------------------------------------
// HSL / RGB LED frame encoder
// Converts colour requests into ten-byte serial LED frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_item and raise push; a transfer takes place at a
//   rising edge with push high and full low. operation selects direct RGB
//   bytes, HSL, or a packed 24-bit RGB word (the unused code acts as direct).
//   Output channel: while empty is low, o_item holds the oldest frame byte;
//   raise pop to take it. Each request yields ten bytes, msb first: four
//   zero bytes, G, R and B as 0x80 | (value >> 1), three 0x80 bytes, the
//   last flagged by last_byte.
//   Path: the first byte of a frame is shown once its request has passed
//   the six conversion stages, the queue and the serialiser registers.
//   Flow: the sustained rate is bounded by the ten bytes per request that
//   pass the single output byte register; requests are taken every cycle until the
//   conversion pipeline and the four-entry colour queue are full.
//   Reset (synchronous, active low) empties pipeline, queue and output.
//   When the receiver stalls, the current byte holds and the frame resumes
//   without loss; full rises once the queue and pipeline back up.
// ----------------------------------------------------------------------------
module hsl_rgb_led_frame_encoder
    import hsle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_item
);

    logic q_push, q_full, q_pop, q_empty;
    t_rgb q_wdata, q_rdata;

    // Convert requests to RGB; stall when the queue cannot take a colour
    hsle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_item),
        .o_q_push (q_push),
        .o_q_data (q_wdata),
        .i_q_full (q_full)
    );

    // Decouple conversion from the byte-rate serialiser
    hsle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // Emit one frame byte per transfer
    hsle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_item)
    );

endmodule
